// ===== rtl/cvk_pkg.sv =====
// cvk_pkg: types, constants and arithmetic helpers for the six-axis Kalman unit.
// No dependencies.
package cvk_pkg;

  localparam int WordBits = 32;
  localparam int MeasCount = 6;
  localparam int OutCount = 12;
  localparam int FracBits = 16;

  typedef logic signed [WordBits-1:0] word_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_STEP_TIME  = 2'd0,
    REG_ACCEL_STD  = 2'd1,
    REG_MEAS_NOISE = 2'd2
  } reg_idx_t;

  localparam logic [16:0] StepTimeReset = 17'd3277;
  localparam logic [19:0] AccelStdReset = 20'd6554;
  localparam logic [19:0] MeasNoiseReset = 20'd6554;

  // Which measurement field feeds each axis (axes x, pitch, y, roll, z, yaw);
  // axes past the sixth wrap around to the same pattern
  function automatic logic [2:0] meas_of_axis(input logic [3:0] a);
    logic [2:0] m;
    begin
      case (a)
        4'd0, 4'd6, 4'd12:  m = 3'd0;
        4'd1, 4'd7, 4'd13:  m = 3'd4;
        4'd2, 4'd8, 4'd14:  m = 3'd1;
        4'd3, 4'd9, 4'd15:  m = 3'd3;
        4'd4, 4'd10:        m = 3'd2;
        4'd5, 4'd11:        m = 3'd5;
        default: m = 3'd0;
      endcase
      return m;
    end
  endfunction

  // Saturate a 34-bit sum to 32-bit signed
  function automatic word_t sat34(input logic signed [33:0] v);
    word_t r;
    begin
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
    end
  endfunction

  function automatic word_t add_sat(input word_t a, input word_t b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic word_t sub_sat(input word_t a, input word_t b);
    return sat34(34'(a) - 34'(b));
  endfunction

  // Datapath command: one micro-op per cycle, with OP_NONE while the sequencer waits
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV_START,
    OP_LOAD,
    OP_STORE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/cvk_datapath.sv =====
// cvk_datapath: shared multiplier, serial divider, per-axis state and temporaries.
// Depends on cvk_pkg. Driven by cvk_ctrl through a micro-step command.
module cvk_datapath #(
  parameter int AXES = 6,
  parameter int AW = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cvk_pkg::dp_cmd_t       cmd,
  input  logic [AW-1:0]          axis,
  input  logic [6*32-1:0]        meas,
  input  logic [16:0]            step_time,
  input  logic [19:0]            accel_std,
  input  logic [19:0]            meas_noise,
  output cvk_pkg::dp_stat_t      stat,
  output logic [12*32-1:0]       est
);
  import cvk_pkg::*;

  localparam int DivBits = 32 + FracBits + 1;
  localparam int CntW = $clog2(DivBits + 1);

  // Per-axis state
  word_t pos_q [AXES];
  word_t vel_q [AXES];
  word_t cpp_q [AXES];
  word_t cpv_q [AXES];
  word_t cvv_q [AXES];

  // Working registers for the current axis and tick constants
  word_t p, v, pp, pv, vv, z, t, e, s, k0, k1;
  word_t g0, q00, q01, q11, tmp;
  word_t ts_w, sg_w, r_w;

  // Multiplier operands and registered result
  word_t ma, mb, mres;
  logic  mul_busy;
  logic signed [63:0] prod_q;

  // Divider
  logic              div_busy;
  logic [CntW-1:0]   div_cnt;
  logic [DivBits-1:0] div_quo;
  logic [DivBits:0]  div_rem;
  logic [DivBits-1:0] div_num;
  logic [32:0]       div_den;
  logic              div_neg;
  logic              div_zero;
  logic              div_sel;
  word_t             div_res;

  word_t mul_out;
  logic signed [63:0] rnd;

  assign ts_w = word_t'({15'd0, step_time});
  assign sg_w = word_t'({12'd0, accel_std});
  assign r_w  = word_t'({12'd0, meas_noise});

  // Rounded product result, floor shift then saturate
  always_comb begin
    rnd = prod_q + (64'sd1 <<< (FracBits - 1));
    rnd = rnd >>> FracBits;
    if (rnd > 64'sh7FFF_FFFF) mul_out = 32'sh7FFF_FFFF;
    else if (rnd < -64'sh8000_0000) mul_out = 32'sh8000_0000;
    else mul_out = rnd[31:0];
  end

  // Operand select per micro-step
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.step)
      4'd0:  begin ma = ts_w; mb = ts_w; end
      4'd1:  begin ma = tmp; mb = word_t'(32'sd1 <<< (FracBits - 1)); end
      4'd2:  begin ma = g0; mb = g0; end
      4'd3:  begin ma = g0; mb = ts_w; end
      4'd4:  begin ma = ts_w; mb = ts_w; end
      4'd5:  begin ma = ts_w; mb = v; end
      4'd6:  begin ma = ts_w; mb = vv; end
      4'd7:  begin ma = ts_w; mb = pv; end
      4'd8:  begin ma = ts_w; mb = t; end
      4'd9:  begin ma = k0; mb = e; end
      4'd10: begin ma = k1; mb = e; end
      4'd11: begin ma = k0; mb = pp; end
      4'd12: begin ma = k0; mb = pv; end
      4'd13: begin ma = k1; mb = pv; end
      4'd14: begin ma = tmp; mb = sg_w; end
      default: begin ma = tmp; mb = sg_w; end
    endcase
  end

  // Divider quotient saturation
  always_comb begin
    logic signed [DivBits:0] sq;
    sq = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    if (div_zero) div_res = '0;
    else if (sq > $signed((DivBits+1)'(32'h7FFF_FFFF))) div_res = 32'sh7FFF_FFFF;
    else if (sq < -$signed((DivBits+1)'(33'h0_8000_0000))) div_res = 32'sh8000_0000;
    else div_res = sq[31:0];
  end

  assign stat.mul_done = mul_busy;
  assign stat.div_done = div_busy && (div_cnt == '0);

  // Outputs: pairs for axes below AXES (at most six), zero otherwise
  always_comb begin
    est = '0;
    for (int k = 0; k < 6; k++) begin
      if (k < AXES) begin
        est[64*k +: 32]      = pos_q[k];
        est[64*k + 32 +: 32] = vel_q[k];
      end
    end
  end

  // Multiplier: register product, result consumed next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
    end else begin
      mul_busy <= (cmd.op == OP_MUL);
    end
    if (cmd.op == OP_MUL) prod_q <= 64'(ma) * 64'(mb);
  end

  // Serial restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.op == OP_DIV_START) begin
      div_busy <= 1'b1;
      div_cnt  <= CntW'(DivBits);
      div_sel  <= cmd.step[0];
      div_zero <= (s == '0);
      div_neg  <= (cmd.step[0] ? pv[31] : pp[31]) ^ s[31];
      div_num  <= DivBits'(
        (cmd.step[0] ? (pv[31] ? -33'(pv) : 33'(pv)) : (pp[31] ? -33'(pp) : 33'(pp)))
        ) << FracBits;
      div_den  <= s[31] ? -33'(s) : 33'(s);
      div_rem  <= '0;
      div_quo  <= '0;
    end else if (div_busy) begin
      if (div_cnt == '0) begin
        div_busy <= 1'b0;
        if (div_sel) k1 <= div_res;
        else k0 <= div_res;
      end else begin
        logic [DivBits:0] trial;
        trial = {div_rem[DivBits-1:0], div_num[DivBits-1]};
        div_num <= div_num << 1;
        if (trial >= (DivBits+1)'(div_den)) begin
          div_rem <= trial - (DivBits+1)'(div_den);
          div_quo <= {div_quo[DivBits-2:0], 1'b1};
        end else begin
          div_rem <= trial;
          div_quo <= {div_quo[DivBits-2:0], 1'b0};
        end
        div_cnt <= div_cnt - 1'b1;
      end
    end
  end

  // Working registers: mul results written back on the cycle after issue; also store and load micro-ops
  always_ff @(posedge clk) begin
    if (mul_busy) begin
      case (cmd.step)
        4'd0:  tmp <= mul_out;                     // Ts*Ts
        4'd1:  g0 <= mul_out;
        4'd2:  tmp <= mul_out;                     // g0*g0 (then *s *s -> q00)
        4'd3:  tmp <= mul_out;
        4'd4:  tmp <= mul_out;
        4'd5:  p <= add_sat(p, mul_out);
        4'd6:  t <= add_sat(pv, mul_out);
        4'd7:  pp <= add_sat(pp, mul_out);
        4'd8:  pp <= add_sat(pp, mul_out);
        4'd9:  p <= add_sat(p, mul_out);
        4'd10: v <= add_sat(v, mul_out);
        4'd11: tmp <= mul_out;
        4'd12: pv <= sub_sat(pv, mul_out);
        4'd13: vv <= sub_sat(vv, mul_out);
        default: tmp <= mul_out;
      endcase
    end
    if (cmd.op == OP_STORE) begin
      case (cmd.step)
        4'd0: q00 <= tmp;
        4'd1: q01 <= tmp;
        4'd2: q11 <= tmp;
        // predicted covariance and innovation variance
        4'd3: begin
          pp <= add_sat(pp, q00);
          pv <= add_sat(t, q01);
          vv <= add_sat(vv, q11);
        end
        4'd4: begin
          s <= add_sat(pp, r_w);
          e <= sub_sat(z, p);
        end
        4'd5: pp <= sub_sat(pp, tmp);
        default: ;
      endcase
    end
    if (cmd.op == OP_LOAD) begin
      p  <= pos_q[axis];
      v  <= vel_q[axis];
      pp <= cpp_q[axis];
      pv <= cpv_q[axis];
      vv <= cvv_q[axis];
      z  <= meas[32*meas_of_axis(4'(axis)) +: 32];
    end
  end

  // Per-axis state writeback
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < AXES; k++) begin
        pos_q[k] <= '0;
        vel_q[k] <= '0;
        cpp_q[k] <= word_t'(32'sd1 <<< FracBits);
        cpv_q[k] <= '0;
        cvv_q[k] <= word_t'(32'sd1 <<< FracBits);
      end
    end else if (cmd.op == OP_STORE && cmd.step == 4'd6) begin
      pos_q[axis] <= p;
      vel_q[axis] <= v;
      cpp_q[axis] <= pp;
      cpv_q[axis] <= pv;
      cvv_q[axis] <= vv;
    end
  end

endmodule

// ===== rtl/cvk_ctrl.sv =====
// cvk_ctrl: sequencer that walks the tick constants and each axis through the datapath.
// Depends on cvk_pkg.
module cvk_ctrl #(
  parameter int AXES = 6,
  parameter int AW = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cvk_pkg::dp_stat_t stat,
  output cvk_pkg::dp_cmd_t  cmd,
  output logic [AW-1:0]     axis,
  output logic              busy,
  output logic              done
);
  import cvk_pkg::*;

  // Program: list of micro-ops; MUL waits in S_WAIT for the writeback, DIV_START in S_DIV for the quotient
  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_DIV,
    S_DONE
  } state_t;

  state_t     state;
  logic [5:0] pc;

  // Micro-program: {op, step}
  function automatic dp_cmd_t prog(input logic [5:0] i);
    dp_cmd_t c;
    begin
      c.op = OP_NONE;
      c.step = 4'd0;
      case (i)
        // tick constants
        6'd0:  begin c.op = OP_MUL;   c.step = 4'd0;  end
        6'd1:  begin c.op = OP_MUL;   c.step = 4'd1;  end
        6'd2:  begin c.op = OP_MUL;   c.step = 4'd2;  end
        6'd3:  begin c.op = OP_MUL;   c.step = 4'd14; end
        6'd4:  begin c.op = OP_MUL;   c.step = 4'd14; end
        6'd5:  begin c.op = OP_STORE; c.step = 4'd0;  end
        6'd6:  begin c.op = OP_MUL;   c.step = 4'd3;  end
        6'd7:  begin c.op = OP_MUL;   c.step = 4'd14; end
        6'd8:  begin c.op = OP_MUL;   c.step = 4'd14; end
        6'd9:  begin c.op = OP_STORE; c.step = 4'd1;  end
        6'd10: begin c.op = OP_MUL;   c.step = 4'd4;  end
        6'd11: begin c.op = OP_MUL;   c.step = 4'd14; end
        6'd12: begin c.op = OP_MUL;   c.step = 4'd14; end
        6'd13: begin c.op = OP_STORE; c.step = 4'd2;  end
        // per-axis program starts here
        6'd14: begin c.op = OP_LOAD;  c.step = 4'd0;  end
        6'd15: begin c.op = OP_MUL;   c.step = 4'd7;  end  // pp += Ts*pv
        6'd16: begin c.op = OP_MUL;   c.step = 4'd6;  end  // t = pv + Ts*vv
        6'd17: begin c.op = OP_MUL;   c.step = 4'd5;  end  // p += Ts*v
        6'd18: begin c.op = OP_MUL;   c.step = 4'd8;  end  // pp += Ts*t
        6'd19: begin c.op = OP_STORE; c.step = 4'd3;  end
        6'd20: begin c.op = OP_STORE; c.step = 4'd4;  end
        6'd21: begin c.op = OP_DIV_START; c.step = 4'd0; end
        6'd22: begin c.op = OP_DIV_START; c.step = 4'd1; end
        6'd23: begin c.op = OP_MUL;   c.step = 4'd9;  end
        6'd24: begin c.op = OP_MUL;   c.step = 4'd10; end
        6'd25: begin c.op = OP_MUL;   c.step = 4'd13; end  // vv uses pv before update
        6'd26: begin c.op = OP_MUL;   c.step = 4'd11; end
        6'd27: begin c.op = OP_MUL;   c.step = 4'd12; end
        6'd28: begin c.op = OP_STORE; c.step = 4'd5;  end
        6'd29: begin c.op = OP_STORE; c.step = 4'd6;  end
        default: ;
      endcase
      return c;
    end
  endfunction

  localparam logic [5:0] AxisStart = 6'd14;
  localparam logic [5:0] AxisEnd = 6'd29;

  dp_cmd_t cur;
  assign cur = prog(pc);

  always_comb begin
    cmd = '0;
    if (state == S_ISSUE) cmd = cur;
    else if (state == S_WAIT) begin
      cmd.op = OP_NONE;
      cmd.step = cur.step;
    end
  end

  assign busy = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      axis  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            pc    <= '0;
            axis  <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (cur.op == OP_MUL) state <= S_WAIT;
          else if (cur.op == OP_DIV_START) state <= S_DIV;
          else if (pc == AxisEnd) begin
            if (32'(axis) == AXES - 1) state <= S_DONE;
            else begin
              axis <= axis + 1'b1;
              pc <= AxisStart;
            end
          end else pc <= pc + 1'b1;
        end
        S_WAIT: begin
          if (stat.mul_done) begin
            pc <= pc + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_DIV: begin
          if (stat.div_done) begin
            pc <= pc + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/constant_velocity_kalman_six_axis_unit.sv =====
// Channel   | Dir | Handshake        | Payload
// s_axis    | in  | tvalid/tready    | six Q16.16 measurements
// m_axis    | out | tvalid/tready    | twelve Q16.16 estimates
// cfg       | in  | cfg_valid/ready  | cfg_index, cfg_data
//
// A tick first runs the tick constants (11 multiplies, 3 stores), then the per-axis program
// for each axis in turn, with two serial divides per axis; m_axis_tvalid is registered from done.
// Reset: synchronous; state returns to zero position and identity covariance.
// Input is taken only when idle and no result is waiting or about to be registered.
module constant_velocity_kalman_six_axis_unit #(
  parameter int AXES = 6
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,  // meas_x, meas_y, meas_z, meas_roll, meas_pitch, meas_yaw
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [383:0] m_axis_tdata,  // est_x, est_dx, est_pitch, est_dpitch, est_y, est_dy,
                                      // est_roll, est_droll, est_z, est_dz, est_yaw, est_dyaw
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import cvk_pkg::*;

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  logic [16:0]  step_time;
  logic [19:0]  accel_std;
  logic [19:0]  meas_noise;
  logic [191:0] meas_q;
  logic [383:0] est;
  dp_cmd_t      cmd;
  dp_stat_t     stat;
  logic [AW-1:0] axis;
  logic         busy, done, start;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = !busy && !done && !m_axis_tvalid;
  assign start = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time  <= StepTimeReset;
      accel_std  <= AccelStdReset;
      meas_noise <= MeasNoiseReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_TIME:  step_time  <= cfg_data[16:0];
        REG_ACCEL_STD:  accel_std  <= cfg_data[19:0];
        REG_MEAS_NOISE: meas_noise <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Measurement capture and output register
  always_ff @(posedge clk) begin
    if (start) meas_q <= s_axis_tdata;
    if (rst) m_axis_tvalid <= 1'b0;
    else if (done) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (done) m_axis_tdata <= est;
  end

  cvk_ctrl #(.AXES(AXES)) u_ctrl (
    .clk, .rst, .start, .stat, .cmd, .axis, .busy, .done
  );

  cvk_datapath #(.AXES(AXES)) u_dp (
    .clk, .rst, .cmd, .axis, .meas(meas_q),
    .step_time, .accel_std(accel_std), .meas_noise(meas_noise), .stat, .est
  );

endmodule

// ===== rtl/cvk_checker.sv =====
// cvk_checker: port-level checks for the Kalman unit, bound to the top level.
// Depends on nothing but the top-level ports.
module cvk_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [383:0] m_axis_tdata
);
  // No new tick while a result waits
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepted while result pending");

  // Result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  // No result right after a tick is taken
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early result");
endmodule

bind constant_velocity_kalman_six_axis_unit cvk_checker u_chk (.*);
